// File: design/fcpu_pkg.sv
// ----------------------------------------------------------------------------
// fcpu_pkg
// Shared types, constants and the quarter-wave sine table of the camera pose
// update block.
// ----------------------------------------------------------------------------
package fcpu_pkg;

  // fixed-point formats
  localparam int POSITION_FRAC_BITS = 16;
  localparam int VECTOR_FRAC_BITS   = 15;

  // rounding of Q45 vector sums down to the vector format
  localparam int VEC_SHIFT = 45 - VECTOR_FRAC_BITS;
  // rounding of step times vector sum down to the position format
  localparam int MOVE_SHIFT = 16 + VECTOR_FRAC_BITS - POSITION_FRAC_BITS;

  typedef logic signed [16:0] sine_t;   // Q15, -1.0 .. +1.0 inclusive
  typedef logic signed [33:0] prod2_t;  // Q30 product of two sines
  typedef logic signed [47:0] q45_t;    // Q45 sums of triple products
  typedef logic signed [15:0] vec_t;    // vector component
  typedef logic signed [17:0] dsum_t;   // signed sum of two vector components
  typedef logic signed [34:0] move_t;   // step times dsum
  typedef logic signed [31:0] pos_t;    // position
  typedef logic signed [8:0]  angle_t;  // whole degrees

  localparam q45_t  VEC_HALF  = 48'sd1 <<< (VEC_SHIFT - 1);
  localparam move_t MOVE_HALF = (35'sd1 <<< MOVE_SHIFT) >>> 1;

  // port geometry
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 184;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROLL      = 2'd3;

  localparam logic [11:0] CENTER_X_RESET  = 12'd320;
  localparam logic [11:0] CENTER_Y_RESET  = 12'd240;
  localparam logic [15:0] STEP_SIZE_RESET = 16'd6554;
  localparam angle_t      ROLL_RESET      = 9'sd0;

  // event kinds
  localparam logic [IN_TUSER_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [IN_TUSER_W-1:0] KIND_MOTION   = 2'd1;
  localparam logic [IN_TUSER_W-1:0] KIND_KEY_DOWN = 2'd2;
  localparam logic [IN_TUSER_W-1:0] KIND_KEY_UP   = 2'd3;

  // key codes
  localparam logic [7:0] KEY_UPPER_A  = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z  = 8'h5A;
  localparam logic [7:0] KEY_CASE_BIT = 8'h20;
  localparam logic [7:0] KEY_W        = 8'h77;
  localparam logic [7:0] KEY_A        = 8'h61;
  localparam logic [7:0] KEY_S        = 8'h73;
  localparam logic [7:0] KEY_D        = 8'h64;

  localparam logic [3:0] HELD_W = 4'b0001;
  localparam logic [3:0] HELD_A = 4'b0010;
  localparam logic [3:0] HELD_S = 4'b0100;
  localparam logic [3:0] HELD_D = 4'b1000;

  localparam angle_t ANGLE_MAX   = 9'sd179;
  localparam angle_t ANGLE_MIN   = -9'sd180;
  localparam angle_t PITCH_RESET = -9'sd90;

  // datapath commands from the controller
  typedef struct packed {
    logic update;  // take the input word and update angles, keys, skip flag
    logic trig;    // look up the six sines
    logic mul1;    // products of two sines
    logic mul2;    // triple products
    logic vec;     // sums, rounding, saturation
    logic mov1;    // step times direction sum
    logic mov2;    // round and add into position
    logic load;    // load the output register
  } fcpu_cmd_t;

  typedef struct packed {
    logic is_tick;
  } fcpu_status_t;

  // round(sin(k deg) * 2^15), k = 0..90
  localparam logic [15:0] SINE_Q15 [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // sine of a whole degree in -180..269
  function automatic sine_t sin_deg(input logic signed [9:0] d);
    logic signed [10:0] ws;
    logic [8:0]         u;
    logic [6:0]         k;
    logic               neg;
    sine_t              mag;
    ws = 11'(d);
    if (ws < 11'sd0) begin
      ws = ws + 11'sd360;
    end
    u = ws[8:0];
    if (u <= 9'd90) begin
      k   = u[6:0];
      neg = 1'b0;
    end else if (u <= 9'd180) begin
      k   = 7'(9'd180 - u);
      neg = 1'b0;
    end else if (u <= 9'd270) begin
      k   = 7'(u - 9'd180);
      neg = 1'b1;
    end else begin
      k   = 7'(9'd360 - u);
      neg = 1'b1;
    end
    mag = {1'b0, SINE_Q15[k]};
    return neg ? -mag : mag;
  endfunction

endpackage

// File: design/fcpu_ctrl.sv
// ----------------------------------------------------------------------------
// fcpu_ctrl
// Sequencer of the pose update: walks one event through trig lookup, two
// multiply steps, vector rounding and, for ticks, the position move.
// ----------------------------------------------------------------------------
module fcpu_ctrl
  import fcpu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  fcpu_status_t status,
  output fcpu_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRIG = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_VEC  = 3'd4;
  localparam logic [2:0] S_MOV1 = 3'd5;
  localparam logic [2:0] S_MOV2 = 3'd6;
  localparam logic [2:0] S_LOAD = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       room;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign room       = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.update = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd.trig  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        cmd.vec   = 1'b1;
        state_nxt = status.is_tick ? S_MOV1 : S_LOAD;
      end
      S_MOV1: begin
        cmd.mov1  = 1'b1;
        state_nxt = S_MOV2;
      end
      S_MOV2: begin
        cmd.mov2  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait here while the previous word is still held downstream
        cmd.load = room;
        if (room) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/fcpu_datapath.sv
// ----------------------------------------------------------------------------
// fcpu_datapath
// Pose state, configuration registers, sine lookup, vector multiply chain,
// position move and output register.
// ----------------------------------------------------------------------------
module fcpu_datapath
  import fcpu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  fcpu_cmd_t              cmd,
  output fcpu_status_t           status,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // configuration
  logic [11:0] center_x_r, center_y_r;
  logic [15:0] step_r;
  angle_t      roll_r;

  // pose state
  pos_t        pos_x_r, pos_z_r, pos_x_nxt, pos_z_nxt;
  angle_t      pitch_r, yaw_r, pitch_nxt, yaw_nxt;
  logic [3:0]  held_r, held_nxt;
  logic        skip_r, skip_nxt;
  logic        tick_r;

  // input word
  logic [7:0]  key_code, key_lc;
  logic [11:0] pointer_x, pointer_y;
  logic [3:0]  key_bit;

  // trig and products
  logic signed [9:0] roll_w;
  sine_t  sa_r, ca_r, sb_r, cb_r, sc_r, cc_r;
  prod2_t m_sc_sa_r, m_cc_sa_r, m_sb_ca_r, m_sb_sa_r, m_cb_ca_r;
  prod2_t m_sc_ca_r, m_cc_ca_r, m_cb_sa_r, m_cc_cb_r;
  logic signed [50:0] p_cc_sbca, p_sc_sbca, p_cc_sbsa, p_sc_sbsa;
  q45_t   t_cc_sbca_r, t_sc_sbca_r, t_cc_sbsa_r, t_sc_sbsa_r;
  q45_t   e_fx, e_fy, e_fz, e_ux, e_uy, e_uz, e_rx, e_rz;
  vec_t   fwd_x_r, fwd_y_r, fwd_z_r, up_x_r, up_y_r, up_z_r, right_x_r, right_z_r;

  // move
  logic   fw_pos, fw_neg, rt_pos, rt_neg;
  dsum_t  dsum_x, dsum_z;
  logic signed [16:0] step_s;
  move_t  mv_x_r, mv_z_r, dx, dz;
  logic signed [35:0] sum_x, sum_z;

  function automatic angle_t step_angle(input angle_t a, input logic inc, input logic dec);
    angle_t r;
    r = a;
    if (inc) begin
      r = (a == ANGLE_MAX) ? ANGLE_MIN : a + 9'sd1;
    end else if (dec) begin
      r = (a == ANGLE_MIN) ? ANGLE_MAX : a - 9'sd1;
    end
    return r;
  endfunction

  function automatic vec_t to_vec(input q45_t q);
    q45_t r;
    r = (q + VEC_HALF) >>> VEC_SHIFT;
    if (r > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -48'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic dsum_t dir_term(input vec_t v, input logic pos, input logic neg);
    dsum_t r;
    r = '0;
    if (pos) begin
      r = 18'(v);
    end else if (neg) begin
      r = -18'(v);
    end
    return r;
  endfunction

  function automatic pos_t sat_pos(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------- update

  assign key_code  = in_tdata[7:0];
  assign pointer_x = in_tdata[19:8];
  assign pointer_y = in_tdata[31:20];

  assign key_lc = (key_code >= KEY_UPPER_A && key_code <= KEY_UPPER_Z)
                  ? (key_code | KEY_CASE_BIT) : key_code;

  always_comb begin
    unique case (key_lc)
      KEY_W:   key_bit = HELD_W;
      KEY_A:   key_bit = HELD_A;
      KEY_S:   key_bit = HELD_S;
      KEY_D:   key_bit = HELD_D;
      default: key_bit = '0;
    endcase
  end

  always_comb begin
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    held_nxt  = held_r;
    skip_nxt  = skip_r;
    if (cmd.update) begin
      unique case (in_tuser)
        KIND_TICK: begin
          held_nxt = held_r;
        end
        KIND_MOTION: begin
          // every other motion is the echo of the pointer recentre
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else begin
            pitch_nxt = step_angle(pitch_r, pointer_y > center_y_r, pointer_y < center_y_r);
            yaw_nxt   = step_angle(yaw_r, pointer_x < center_x_r, pointer_x > center_x_r);
            skip_nxt  = 1'b1;
          end
        end
        KIND_KEY_DOWN: held_nxt = held_r | key_bit;
        KIND_KEY_UP:   held_nxt = held_r & ~key_bit;
      endcase
    end
  end

  // ------------------------------------------------------------------ move

  assign fw_pos = (held_r & HELD_W) != '0 && (held_r & HELD_S) == '0;
  assign fw_neg = (held_r & HELD_S) != '0 && (held_r & HELD_W) == '0;
  assign rt_pos = (held_r & HELD_D) != '0 && (held_r & HELD_A) == '0;
  assign rt_neg = (held_r & HELD_A) != '0 && (held_r & HELD_D) == '0;

  assign dsum_x = dir_term(fwd_x_r, fw_pos, fw_neg) + dir_term(right_x_r, rt_pos, rt_neg);
  assign dsum_z = dir_term(fwd_z_r, fw_pos, fw_neg) + dir_term(right_z_r, rt_pos, rt_neg);
  assign step_s = {1'b0, step_r};

  assign dx    = (mv_x_r + MOVE_HALF) >>> MOVE_SHIFT;
  assign dz    = (mv_z_r + MOVE_HALF) >>> MOVE_SHIFT;
  assign sum_x = 36'(pos_x_r) + 36'(dx);
  assign sum_z = 36'(pos_z_r) + 36'(dz);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_z_nxt = pos_z_r;
    if (cmd.mov2) begin
      pos_x_nxt = sat_pos(sum_x);
      pos_z_nxt = sat_pos(sum_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RESET;
      center_y_r <= CENTER_Y_RESET;
      step_r     <= STEP_SIZE_RESET;
      roll_r     <= ROLL_RESET;
      pos_x_r    <= '0;
      pos_z_r    <= '0;
      pitch_r    <= PITCH_RESET;
      yaw_r      <= '0;
      held_r     <= '0;
      skip_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_CENTER_X:  center_x_r <= cfg_wdata[11:0];
          CFG_CENTER_Y:  center_y_r <= cfg_wdata[11:0];
          CFG_STEP_SIZE: step_r     <= cfg_wdata;
          CFG_ROLL:      roll_r     <= cfg_wdata[8:0];
        endcase
      end
      pos_x_r <= pos_x_nxt;
      pos_z_r <= pos_z_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
      held_r  <= held_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // ------------------------------------------------------------ trig chain

  // roll register may hold -256..255, fold into -180..179
  always_comb begin
    roll_w = 10'(roll_r);
    if (roll_w > 10'sd179) begin
      roll_w = roll_w - 10'sd360;
    end else if (roll_w < -10'sd180) begin
      roll_w = roll_w + 10'sd360;
    end
  end

  assign p_cc_sbca = cc_r * m_sb_ca_r;
  assign p_sc_sbca = sc_r * m_sb_ca_r;
  assign p_cc_sbsa = cc_r * m_sb_sa_r;
  assign p_sc_sbsa = sc_r * m_sb_sa_r;

  assign e_fx = -((48'(m_sc_sa_r) <<< 15) + t_cc_sbca_r);
  assign e_fy = (48'(m_cc_sa_r) <<< 15) - t_sc_sbca_r;
  assign e_fz = -(48'(m_cb_ca_r) <<< 15);
  assign e_ux = t_cc_sbsa_r - (48'(m_sc_ca_r) <<< 15);
  assign e_uy = (48'(m_cc_ca_r) <<< 15) + t_sc_sbsa_r;
  assign e_uz = 48'(m_cb_sa_r) <<< 15;
  assign e_rx = 48'(m_cc_cb_r) <<< 15;
  assign e_rz = -(48'(sb_r) <<< 30);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      tick_r <= (in_tuser == KIND_TICK);
    end
    if (cmd.trig) begin
      sa_r <= sin_deg(10'(pitch_r));
      ca_r <= sin_deg(10'(pitch_r) + 10'sd90);
      sb_r <= sin_deg(10'(yaw_r));
      cb_r <= sin_deg(10'(yaw_r) + 10'sd90);
      sc_r <= sin_deg(roll_w);
      cc_r <= sin_deg(roll_w + 10'sd90);
    end
    if (cmd.mul1) begin
      m_sc_sa_r <= sc_r * sa_r;
      m_cc_sa_r <= cc_r * sa_r;
      m_sb_ca_r <= sb_r * ca_r;
      m_sb_sa_r <= sb_r * sa_r;
      m_cb_ca_r <= cb_r * ca_r;
      m_sc_ca_r <= sc_r * ca_r;
      m_cc_ca_r <= cc_r * ca_r;
      m_cb_sa_r <= cb_r * sa_r;
      m_cc_cb_r <= cc_r * cb_r;
    end
    if (cmd.mul2) begin
      t_cc_sbca_r <= p_cc_sbca[47:0];
      t_sc_sbca_r <= p_sc_sbca[47:0];
      t_cc_sbsa_r <= p_cc_sbsa[47:0];
      t_sc_sbsa_r <= p_sc_sbsa[47:0];
    end
    if (cmd.vec) begin
      fwd_x_r   <= to_vec(e_fx);
      fwd_y_r   <= to_vec(e_fy);
      fwd_z_r   <= to_vec(e_fz);
      up_x_r    <= to_vec(e_ux);
      up_y_r    <= to_vec(e_uy);
      up_z_r    <= to_vec(e_uz);
      right_x_r <= to_vec(e_rx);
      right_z_r <= to_vec(e_rz);
    end
    if (cmd.mov1) begin
      mv_x_r <= step_s * dsum_x;
      mv_z_r <= step_s * dsum_z;
    end
    if (cmd.load) begin
      out_tdata <= {6'd0, up_z_r, up_y_r, up_x_r, fwd_z_r, fwd_y_r, fwd_x_r,
                    yaw_r, pitch_r, pos_z_r, pos_x_r};
    end
  end

  assign status.is_tick = tick_r;

endmodule

// File: design/fly_camera_pose_update.sv
// ----------------------------------------------------------------------------
// fly_camera_pose_update
// First-person camera pose engine: key, pointer and tick events in, full
// pose (position, angles, forward and up vectors) out.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one word per event, kind on in_tuser, key code and pointer
//   position on in_tdata. Every accepted word yields exactly one output word
//   holding the pose after the event.
//   The output word is loaded after the sine lookup, two multiply steps and
//   rounding; a tick adds the step multiply and position add before the
//   load. One event is in flight at a time; in_tready returns after the
//   result is loaded, as every step runs through one shared datapath, so
//   no new event is taken while one is worked on.
//   If out_tready is low the finished word holds in the output register;
//   the next event is still accepted and worked on, and waits for the
//   register before it is loaded.
//   Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at
//   the clock edge and belong to idle periods.
//   Synchronous reset restores the default centre, step and roll, clears
//   position and held keys, sets pitch to -90 and yaw to 0.
// ----------------------------------------------------------------------------
module fly_camera_pose_update
  import fcpu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key_code[7:0], pointer_x[19:8], pointer_y[31:20]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // position_x[31:0], position_z[63:32], pitch_deg[72:64], yaw_deg[81:73],
  // forward_x[97:82], forward_y[113:98], forward_z[129:114],
  // up_x[145:130], up_y[161:146], up_z[177:162], zero pad[183:178]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  fcpu_cmd_t    cmd;
  fcpu_status_t status;

  fcpu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  fcpu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

// File: tb/sv/fly_camera_pose_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fly_camera_pose_update_tb
// Self-checking bench for the camera pose block. A clocked driver feeds event
// words from a queue and predicts each pose as the word is taken; a clocked
// monitor compares every pose word, field by field, with the oldest
// prediction. Both sides stall at random except in one phase, and the register
// settings change between phases once the block has drained.
// ----------------------------------------------------------------------------
module fly_camera_pose_update_tb;
  import fcpu_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT     = 28;
  localparam int FIELD_COUNT  = 11;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          VEC_ONE = 64'sd32768;
  localparam logic [7:0]      KEY_ESCAPE = 8'h1B;
  localparam logic [11:0]     COORD_MAX  = 12'hFFF;

  // pointer side relative to the centre
  localparam int SIDE_BELOW = 0;
  localparam int SIDE_EQUAL = 1;
  localparam int SIDE_ABOVE = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic [11:0] px;
    logic [11:0] py;
  } cam_event_t;

  typedef struct packed {
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] right_x;
    logic signed [31:0] right_z;
  } view_vecs_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow registers and pose
  logic [11:0] sh_center_x;
  logic [11:0] sh_center_y;
  logic [15:0] sh_step;
  logic [8:0]  sh_roll;
  int          cam_pos_x;
  int          cam_pos_z;
  int          cam_pitch;
  int          cam_yaw;
  logic [3:0]  cam_held;
  bit          cam_skip;

  cam_event_t             event_q [$];
  cam_event_t             shown_ev;
  logic [OUT_TDATA_W-1:0] pose_q [$];

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int results_cnt  = 0;
  int errors       = 0;
  int cycle_cnt    = 0;
  int tick_cnt     = 0;
  int motion_cnt   = 0;
  int key_cnt      = 0;
  bit stall_en     = 1'b1;

  fly_camera_pose_update u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // taylor series of sin(k deg) in q30, rounded to q15
  function automatic longint quarter_sine(input int k);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    kk   = 64'(k);
    x    = (kk * PI_Q30) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return (sum + 64'sd16384) >>> 15;
  endfunction

  function automatic longint sine_of(input int d);
    int u;
    u = ((d % 360) + 360) % 360;
    if (u <= 90) return quarter_sine(u);
    if (u <= 180) return quarter_sine(180 - u);
    if (u <= 270) return -quarter_sine(u - 180);
    return -quarter_sine(360 - u);
  endfunction

  function automatic int wrap_angle(input int d);
    return ((((d + 180) % 360) + 360) % 360) - 180;
  endfunction

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clamp_vec(input longint q);
    longint r;
    r = round_half_up(q, 45 - VECTOR_FRAC_BITS);
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return int'(r);
  endfunction

  function automatic view_vecs_t view_vectors();
    longint     sa;
    longint     ca;
    longint     sb;
    longint     cb;
    longint     sc;
    longint     cc;
    int         roll;
    view_vecs_t v;
    roll = wrap_angle(int'($signed(sh_roll)));
    sa = sine_of(cam_pitch);
    ca = sine_of(cam_pitch + 90);
    sb = sine_of(cam_yaw);
    cb = sine_of(cam_yaw + 90);
    sc = sine_of(roll);
    cc = sine_of(roll + 90);
    v.fwd_x   = clamp_vec(-(sc * sa * VEC_ONE + cc * sb * ca));
    v.fwd_y   = clamp_vec(-(-cc * sa * VEC_ONE + sc * sb * ca));
    v.fwd_z   = clamp_vec(-(cb * ca * VEC_ONE));
    v.up_x    = clamp_vec(-sc * ca * VEC_ONE + cc * sb * sa);
    v.up_y    = clamp_vec(cc * ca * VEC_ONE + sc * sb * sa);
    v.up_z    = clamp_vec(cb * sa * VEC_ONE);
    v.right_x = clamp_vec(cc * cb * VEC_ONE);
    v.right_z = clamp_vec(-sb * VEC_ONE * VEC_ONE);
    return v;
  endfunction

  function automatic int move_axis(input int p, input int f, input int r,
                                   input int mf, input int mr);
    longint dir;
    longint delta;
    dir   = longint'(mf) * f + longint'(mr) * r;
    delta = longint'(sh_step) * dir;
    delta = round_half_up(delta, 16 + VECTOR_FRAC_BITS - POSITION_FRAC_BITS) + longint'(p);
    if (delta > 64'sd2147483647) delta = 64'sd2147483647;
    if (delta < -64'sd2147483648) delta = -64'sd2147483648;
    return int'(delta);
  endfunction

  function automatic int sign_int(input int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // advance the shadow pose by one event and return the expected word
  function automatic logic [OUT_TDATA_W-1:0] predict_pose(input cam_event_t ev);
    view_vecs_t v;
    int         mf;
    int         mr;
    logic [7:0] key;
    logic [3:0] key_flag;
    case (ev.kind)
      KIND_TICK: begin
        mf = (((cam_held & HELD_W) != 0) ? 1 : 0) - (((cam_held & HELD_S) != 0) ? 1 : 0);
        mr = (((cam_held & HELD_D) != 0) ? 1 : 0) - (((cam_held & HELD_A) != 0) ? 1 : 0);
        v = view_vectors();
        cam_pos_x = move_axis(cam_pos_x, v.fwd_x, v.right_x, mf, mr);
        cam_pos_z = move_axis(cam_pos_z, v.fwd_z, v.right_z, mf, mr);
      end
      KIND_MOTION: begin
        if (!cam_skip) begin
          cam_pitch = wrap_angle(cam_pitch + sign_int(int'(ev.py) - int'(sh_center_y)));
          cam_yaw   = wrap_angle(cam_yaw - sign_int(int'(ev.px) - int'(sh_center_x)));
          cam_skip  = 1'b1;
        end else begin
          cam_skip = 1'b0;
        end
      end
      default: begin
        key = ev.key;
        if (key >= KEY_UPPER_A && key <= KEY_UPPER_Z) key = key + KEY_CASE_BIT;
        key_flag = '0;
        if (key == KEY_W) key_flag = HELD_W;
        else if (key == KEY_A) key_flag = HELD_A;
        else if (key == KEY_S) key_flag = HELD_S;
        else if (key == KEY_D) key_flag = HELD_D;
        if (ev.kind == KIND_KEY_DOWN) begin
          cam_held = cam_held | key_flag;
        end else begin
          cam_held = cam_held & ~key_flag;
        end
      end
    endcase
    v = view_vectors();
    return {6'd0, 16'(v.up_z), 16'(v.up_y), 16'(v.up_x), 16'(v.fwd_z), 16'(v.fwd_y),
            16'(v.fwd_x), 9'(cam_yaw), 9'(cam_pitch), 32'(cam_pos_z), 32'(cam_pos_x)};
  endfunction

  // ----------------------------------------------------------------- stimulus

  task automatic push_event(input logic [1:0] kind, input logic [7:0] key,
                            input logic [11:0] px, input logic [11:0] py);
    cam_event_t ev;
    ev.kind = kind;
    ev.key  = key;
    ev.px   = px;
    ev.py   = py;
    event_q.push_back(ev);
    pushed_cnt++;
    if (kind == KIND_TICK) tick_cnt++;
    else if (kind == KIND_MOTION) motion_cnt++;
    else key_cnt++;
  endtask

  function automatic logic [11:0] side_coord(input logic [11:0] c, input int side);
    if (side == SIDE_BELOW) return (c == 12'd0) ? c : 12'($urandom_range(0, c - 1));
    if (side == SIDE_ABOVE) return (c == COORD_MAX) ? c : 12'($urandom_range(c + 1, COORD_MAX));
    return c;
  endfunction

  // one of w, a, s, d in either case
  function automatic logic [7:0] held_key(input int k);
    logic [7:0] code;
    case (k)
      0:       code = KEY_W;
      1:       code = KEY_A;
      2:       code = KEY_S;
      default: code = KEY_D;
    endcase
    if ($urandom_range(0, 1) == 1) code = code - KEY_CASE_BIT;
    return code;
  endfunction

  task automatic run_random(input int n);
    int         target;
    int         pick;
    int         dx;
    int         dy;
    logic [3:0] picks;
    target = pushed_cnt + n;
    while (pushed_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // pointer drag: a move and its recentre echo, same direction throughout
        dx = ($urandom_range(0, 9) == 0) ? SIDE_EQUAL : 2 * $urandom_range(0, 1);
        dy = ($urandom_range(0, 9) == 0) ? SIDE_EQUAL : 2 * $urandom_range(0, 1);
        repeat ($urandom_range(2, 40)) begin
          push_event(KIND_MOTION, 8'($urandom), side_coord(sh_center_x, dx),
                     side_coord(sh_center_y, dy));
          push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
        end
      end else if (pick < 65) begin
        // walk: press some keys, tick, release some
        picks = 4'($urandom);
        for (int k = 0; k < 4; k++) begin
          if (picks[k]) push_event(KIND_KEY_DOWN, held_key(k), 12'($urandom), 12'($urandom));
        end
        repeat ($urandom_range(2, 20)) begin
          if ($urandom_range(0, 7) == 0) begin
            push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
          end
          push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
        end
        picks = 4'($urandom);
        for (int k = 0; k < 4; k++) begin
          if (picks[k]) push_event(KIND_KEY_UP, held_key(k), 12'($urandom), 12'($urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_event(2'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
        end
      end
    end
  endtask

  // sender holds off until every pose word is back, then lets the block settle
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER_X:  sh_center_x = val[11:0];
      CFG_CENTER_Y:  sh_center_y = val[11:0];
      CFG_STEP_SIZE: sh_step     = val[15:0];
      default:       sh_roll     = val[8:0];
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                           input logic [CFG_DATA_W-1:0] step,
                           input logic [CFG_DATA_W-1:0] roll);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_ROLL, roll);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int dist_p;
    int dist_y;
    int side_p;
    int side_y;
    sh_center_x = CENTER_X_RESET;
    sh_center_y = CENTER_Y_RESET;
    sh_step     = STEP_SIZE_RESET;
    sh_roll     = ROLL_RESET;
    cam_pos_x   = 0;
    cam_pos_z   = 0;
    cam_pitch   = int'(PITCH_RESET);
    cam_yaw     = 0;
    cam_held    = '0;
    cam_skip    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset settings
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_W, 12'($urandom), 12'($urandom));
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_D - KEY_CASE_BIT, 12'($urandom), 12'($urandom));
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_S, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_A, 12'($urandom), 12'($urandom));
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_UP, KEY_W - KEY_CASE_BIT, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_UP, KEY_S, 12'($urandom), 12'($urandom));
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    // keys outside w, a, s, d and just outside the folded range
    push_event(KIND_KEY_DOWN, KEY_ESCAPE, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_UP, 8'hFF, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, 8'h00, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_UPPER_A - 8'd1, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_DOWN, KEY_UPPER_Z + 8'd1, 12'($urandom), 12'($urandom));
    // pointer corners, echo skipping, motion at the centre
    push_event(KIND_MOTION, 8'($urandom), 12'd0, COORD_MAX);
    push_event(KIND_MOTION, 8'($urandom), COORD_MAX, 12'd0);
    push_event(KIND_MOTION, 8'($urandom), COORD_MAX, 12'd0);
    push_event(KIND_MOTION, 8'($urandom), sh_center_x, sh_center_y);
    push_event(KIND_MOTION, 8'($urandom), sh_center_x, sh_center_y);
    push_event(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_UP, KEY_D, 12'($urandom), 12'($urandom));
    push_event(KIND_KEY_UP, KEY_A - KEY_CASE_BIT, 12'($urandom), 12'($urandom));
    wait_idle();

    // corner centre, full step, extreme roll; no stalls on either side
    stall_en = 1'b0;
    configure(16'h0000, 16'h0000, 16'hFFFF, 16'd179);
    run_random(220);
    wait_idle();
    stall_en = 1'b1;

    // far corner, zero step, most negative roll with junk in the upper bits
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFF4C);
    run_random(220);
    wait_idle();

    // mid centre, random step and raw roll, then a sweep across the angle wrap
    configure({4'($urandom), 12'd2048}, {4'($urandom), 12'd2048}, 16'($urandom),
              16'($urandom));
    if (cam_skip) push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
    if (180 - cam_pitch <= cam_pitch + 181) begin
      dist_p = 180 - cam_pitch;
      side_p = SIDE_ABOVE;
    end else begin
      dist_p = cam_pitch + 181;
      side_p = SIDE_BELOW;
    end
    if (180 - cam_yaw <= cam_yaw + 181) begin
      dist_y = 180 - cam_yaw;
      side_y = SIDE_BELOW;
    end else begin
      dist_y = cam_yaw + 181;
      side_y = SIDE_ABOVE;
    end
    repeat (((dist_p > dist_y) ? dist_p : dist_y) + 3) begin
      push_event(KIND_MOTION, 8'($urandom), side_coord(sh_center_x, side_y),
                 side_coord(sh_center_y, side_p));
      push_event(KIND_MOTION, 8'($urandom), 12'($urandom), 12'($urandom));
    end
    run_random(80);
    wait_idle();

    // random centre, smallest step, roll outside the degree range
    configure(16'($urandom), 16'($urandom), 16'd1, 16'h0100);
    run_random(160);
    wait_idle();

    $display("checked %0d pose words: %0d ticks, %0d pointer moves, %0d key events",
             results_cnt, tick_cnt, motion_cnt, key_cnt);
    $display("five register settings incl. corner centres, zero and full step, angle wrap");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ------------------------------------------------------------ driver/monitor

  always @(posedge clk) begin : drive_events
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pose_q.push_back(predict_pose(shown_ev));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (event_q.size() != 0 && !(stall_en && $urandom_range(0, 99) < IDLE_PCT)) begin
          shown_ev = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {shown_ev.py, shown_ev.px, shown_ev.key};
          in_tuser  <= shown_ev.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    logic [OUT_TDATA_W-1:0] want;
    logic [31:0]            want_f;
    logic [31:0]            got_f;
    int                     lsb;
    int                     width;
    string                  fname;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_cnt++;
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: pose word with nothing expected: %h", $time, out_tdata);
        end else begin
          want = pose_q.pop_front();
          lsb  = 0;
          for (int f = 0; f < FIELD_COUNT; f++) begin
            case (f)
              0:       begin width = 32; fname = "position_x"; end
              1:       begin width = 32; fname = "position_z"; end
              2:       begin width = 9;  fname = "pitch_deg";  end
              3:       begin width = 9;  fname = "yaw_deg";    end
              4:       begin width = 16; fname = "forward_x";  end
              5:       begin width = 16; fname = "forward_y";  end
              6:       begin width = 16; fname = "forward_z";  end
              7:       begin width = 16; fname = "up_x";       end
              8:       begin width = 16; fname = "up_y";       end
              9:       begin width = 16; fname = "up_z";       end
              default: begin width = 6;  fname = "pad";        end
            endcase
            want_f = 32'((want >> lsb) & ((184'd1 << width) - 184'd1));
            got_f  = 32'((out_tdata >> lsb) & ((184'd1 << width) - 184'd1));
            if (want_f !== got_f) begin
              errors++;
              $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want_f, got_f);
            end
            lsb = lsb + width;
          end
        end
      end
      out_tready <= !(stall_en && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d words still expected", cycle_cnt,
               pose_q.size() + pushed_cnt - accepted_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
